[src/csc_pkg.sv]
`default_nettype none

package csc_pkg;

  localparam int unsigned CHAN_W = 8;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    chan_t a;
    chan_t b;
    chan_t c;
  } pix_t;

  typedef enum logic [2:0] {
    SP_RGB   = 3'd0,
    SP_HSL   = 3'd1,
    SP_HSV   = 3'd2,
    SP_Y601  = 3'd3,
    SP_Y709  = 3'd4,
    SP_YCOCG = 3'd5,
    SP_CMY   = 3'd6
  } space_e;

  localparam logic REG_SRC = 1'b0;
  localparam logic REG_TGT = 1'b1;

  // Inverse YCbCr coefficients, Q16.
  localparam logic [16:0] K601_CR_R = 17'd91881;
  localparam logic [16:0] K601_CB_B = 17'd116130;
  localparam logic [16:0] K601_CB_G = 17'd22553;
  localparam logic [16:0] K601_CR_G = 17'd46802;
  localparam logic [16:0] K709_CR_R = 17'd103206;
  localparam logic [16:0] K709_CB_B = 17'd121609;
  localparam logic [16:0] K709_CB_G = 17'd12276;
  localparam logic [16:0] K709_CR_G = 17'd30679;

  // Forward YCbCr coefficients, Q16.
  localparam logic [15:0] K601_KR = 16'd19595;
  localparam logic [15:0] K601_KG = 16'd38470;
  localparam logic [15:0] K601_KB = 16'd7471;
  localparam logic [15:0] K601_CB_F = 16'd36984;
  localparam logic [15:0] K601_CR_F = 16'd46745;
  localparam logic [15:0] K709_KR = 16'd13933;
  localparam logic [15:0] K709_KG = 16'd46871;
  localparam logic [15:0] K709_KB = 16'd4732;
  localparam logic [15:0] K709_CB_F = 16'd35318;
  localparam logic [15:0] K709_CR_F = 16'd41615;

  // Chroma offset of 127.5 in Q16.
  localparam logic [27:0] HALF_OFF = 28'd8355840;

  // Reciprocals for division by 255*255 and by 255.
  localparam logic [16:0] RCP_65025 = 17'd66051;
  localparam logic [24:0] RCP_255   = 25'd16843009;

  function automatic chan_t sat8(input logic signed [31:0] v);
    chan_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > 32'sd255) begin
      r = '1;
    end else begin
      r = v[CHAN_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/color_space_converter_unit.sv]
// Color space converter, one pixel of three 8-bit channels per word.
// The source and target spaces are set over the APB port: register 0 at
// byte address 0 holds the source space and register 1 at address 4 holds
// the target space (0 RGB, 1 HSL, 2 HSV, 3 YCbCr601, 4 YCbCr709, 5 YCoCg,
// 6 CMY). Write them only while no word is in flight.
// Input words arrive on the s_axis channel and results leave on m_axis.
// The block takes one word per clock cycle while the skid register is empty.
// A word passes 16 register stages on its way to m_axis:
// six stages bring the pixel to RGB, nine stages bring it to the target
// space, with hue and saturation formed by two dividers that resolve one
// quotient bit per stage, and one output register.
// When the receiver stalls, the word that leaves the pipeline is held in a
// skid register and intake stops until that register drains, so no word is
// lost or repeated.
// Reset clears both space registers to RGB and empties the pipeline.
`default_nettype none

module color_space_converter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // chan_a_in, chan_b_in, chan_c_in
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata    // chan_a_out, chan_b_out, chan_c_out
);
  import csc_pkg::*;

  localparam int unsigned LAT = 15;

  logic [2:0] src_q, tgt_q;
  logic       en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= 3'(SP_RGB);
      tgt_q <= 3'(SP_RGB);
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_SRC: src_q <= pwdata[2:0];
        default: tgt_q <= pwdata[2:0];
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = {29'b0, (paddr[2] == REG_TGT) ? tgt_q : src_q};

  pix_t in_pix;
  assign in_pix = '{a: s_axis_tdata[7:0], b: s_axis_tdata[15:8], c: s_axis_tdata[23:16]};

  logic tr_v, fr_v;
  pix_t tr_pix, fr_pix;

  csc_to_rgb u_to_rgb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .src_i   (space_e'(src_q)),
    .pix_i   (in_pix),
    .valid_o (tr_v),
    .rgb_o   (tr_pix)
  );

  csc_from_rgb u_from_rgb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tr_v),
    .tgt_i   (space_e'(tgt_q)),
    .rgb_i   (tr_pix),
    .valid_o (fr_v),
    .pix_o   (fr_pix)
  );

  pix_t raw_q [LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      raw_q[0] <= in_pix;
      for (int i = 1; i < LAT; i++) begin
        raw_q[i] <= raw_q[i-1];
      end
    end
  end

  pix_t res;
  assign res = (src_q == tgt_q) ? raw_q[LAT-1] : fr_pix;

  logic out_v_q, skid_v_q;
  pix_t out_q, skid_q;
  logic out_free;

  assign en            = !skid_v_q;
  assign s_axis_tready = en;
  assign out_free      = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= fr_v;
      end
    end else if (en) begin
      skid_v_q <= fr_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (en) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.c, out_q.b, out_q.a};

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid word held while output register empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && m_axis_tready) |=> (out_v_q && !skid_v_q))
    else $error("skid word not moved to output");

  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready && fr_v && en) |=> skid_v_q)
    else $error("pipeline word dropped during stall");

endmodule

`default_nettype wire

[src/csc_div.sv]
`default_nettype none

module csc_div #(
  parameter int unsigned NW = 19,
  parameter int unsigned DW = 11
) (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [NW-1:0]             num_i,
  input  wire logic [DW-1:0]             den_i,
  output logic [csc_pkg::CHAN_W-1:0]     quo_o
);
  import csc_pkg::*;

  localparam int unsigned QW = CHAN_W;
  localparam int unsigned CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic          zero_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic          zero_in;
    logic [CW-1:0] shd;
    logic [CW-1:0] diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign zero_in = (den_i == '0);
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign zero_in = zero_q[k-1];
    end

    assign shd  = CW'(den_in) << (QW - 1 - k);
    assign ge   = CW'(rem_in) >= shd;
    assign diff = CW'(rem_in) - shd;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[NW-1:0] : rem_in;
        den_q[k]  <= den_in;
        quo_q[k]  <= {quo_in[QW-2:0], ge};
        zero_q[k] <= zero_in;
      end
    end
  end

  assign quo_o = zero_q[QW-1] ? '0 : quo_q[QW-1];

endmodule

`default_nettype wire

[src/csc_to_rgb.sv]
`default_nettype none

module csc_to_rgb (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire csc_pkg::space_e src_i,
  input  wire csc_pkg::pix_t   pix_i,
  output logic                 valid_o,
  output csc_pkg::pix_t        rgb_o
);
  import csc_pkg::*;

  logic [6:1] v_q;

  // Stage 1 combinational.
  logic [10:0] s6;
  logic [10:0] m;
  logic [2:0]  sector;
  chan_t       t;
  logic [8:0]  lc2;
  chan_t       f;
  chan_t       fac;
  logic        y709;
  logic [16:0] k_crr, k_cbb, k_cbg, k_crg;
  logic signed [9:0]  dcb, dcr;
  logic signed [10:0] av, bv, cv, ir, ig, ib;
  pix_t        simple;

  always_comb begin
    s6 = 11'(pix_i.a) * 11'd6;
    if (s6 >= 11'd1275) begin
      sector = 3'd5;
    end else if (s6 >= 11'd1020) begin
      sector = 3'd4;
    end else if (s6 >= 11'd765) begin
      sector = 3'd3;
    end else if (s6 >= 11'd510) begin
      sector = 3'd2;
    end else if (s6 >= 11'd255) begin
      sector = 3'd1;
    end else begin
      sector = 3'd0;
    end
    if (s6 >= 11'd1530) begin
      m = s6 - 11'd1530;
    end else if (s6 >= 11'd1020) begin
      m = s6 - 11'd1020;
    end else if (s6 >= 11'd510) begin
      m = s6 - 11'd510;
    end else begin
      m = s6;
    end
    t = (m >= 11'd255) ? 8'(11'd510 - m) : m[7:0];

    lc2 = {pix_i.c, 1'b0};
    f   = (lc2 >= 9'd255) ? 8'(9'd510 - lc2) : lc2[7:0];
    fac = (src_i == SP_HSL) ? f : pix_i.c;

    y709  = (src_i == SP_Y709);
    k_crr = y709 ? K709_CR_R : K601_CR_R;
    k_cbb = y709 ? K709_CB_B : K601_CB_B;
    k_cbg = y709 ? K709_CB_G : K601_CB_G;
    k_crg = y709 ? K709_CR_G : K601_CR_G;
    dcb   = $signed({1'b0, pix_i.b, 1'b0}) - 10'sd255;
    dcr   = $signed({1'b0, pix_i.c, 1'b0}) - 10'sd255;

    av = $signed({3'b0, pix_i.a});
    bv = $signed({3'b0, pix_i.b});
    cv = $signed({3'b0, pix_i.c});
    ir = av + bv - cv;
    ig = (11'sd2 * av + 11'sd2 * cv - 11'sd255) >>> 1;
    ib = av - bv - cv + 11'sd255;

    case (src_i)
      SP_YCOCG: begin
        simple.a = sat8(32'(ir));
        simple.b = sat8(32'(ig));
        simple.c = sat8(32'(ib));
      end
      SP_CMY: begin
        simple.a = ~pix_i.a;
        simple.b = ~pix_i.b;
        simple.c = ~pix_i.c;
      end
      default: begin
        simple = pix_i;
      end
    endcase
  end

  logic [2:0]  s1_sector_q;
  chan_t       s1_t_q, s1_c_q, s1_a_q;
  logic [15:0] s1_p_q;
  logic signed [27:0] s1_pr_q, s1_pg1_q, s1_pg2_q, s1_pb_q;
  pix_t        s1_simple_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sector_q <= sector;
      s1_t_q      <= t;
      s1_c_q      <= pix_i.c;
      s1_a_q      <= pix_i.a;
      s1_p_q      <= 16'(fac) * 16'(pix_i.b);
      s1_pr_q     <= $signed({1'b0, k_crr}) * dcr;
      s1_pg1_q    <= $signed({1'b0, k_cbg}) * dcb;
      s1_pg2_q    <= $signed({1'b0, k_crg}) * dcr;
      s1_pb_q     <= $signed({1'b0, k_cbb}) * dcb;
      s1_simple_q <= simple;
    end
  end

  // Stage 2: inverse YCbCr sums and chroma reciprocal estimate.
  logic signed [31:0] yr, yg, yb, gsum;
  logic [32:0] cprod;
  pix_t        lin;

  always_comb begin
    yr    = $signed({24'b0, s1_a_q}) + 32'(s1_pr_q >>> 17);
    gsum  = -32'(s1_pg1_q >>> 1) - 32'(s1_pg2_q >>> 1);
    yg    = $signed({24'b0, s1_a_q}) + (gsum >>> 16);
    yb    = $signed({24'b0, s1_a_q}) + 32'(s1_pb_q >>> 17);
    cprod = 33'(s1_p_q) * 33'(RCP_65025);
    if (src_i == SP_Y601 || src_i == SP_Y709) begin
      lin.a = sat8(yr);
      lin.b = sat8(yg);
      lin.c = sat8(yb);
    end else begin
      lin = s1_simple_q;
    end
  end

  logic [2:0]  s2_sector_q;
  chan_t       s2_t_q, s2_c_q;
  logic [15:0] s2_p_q;
  logic [16:0] s2_q0_q;
  pix_t        s2_lin_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_sector_q <= s1_sector_q;
      s2_t_q      <= s1_t_q;
      s2_c_q      <= s1_c_q;
      s2_p_q      <= s1_p_q;
      s2_q0_q     <= cprod[32:16];
      s2_lin_q    <= lin;
    end
  end

  // Stage 3: chroma correction.
  logic [32:0] crem;
  logic [16:0] cq;

  always_comb begin
    crem = {1'b0, s2_p_q, 16'b0} - 33'(s2_q0_q) * 33'd65025;
    cq   = s2_q0_q + 17'(crem >= 33'd65025);
  end

  logic [2:0]  s3_sector_q;
  chan_t       s3_t_q, s3_c_q;
  logic [16:0] s3_cq_q;
  pix_t        s3_lin_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_sector_q <= s2_sector_q;
      s3_t_q      <= s2_t_q;
      s3_c_q      <= s2_c_q;
      s3_cq_q     <= cq;
      s3_lin_q    <= s2_lin_q;
    end
  end

  // Stage 4: minimum level and the X product.
  logic [16:0] cqm;
  assign cqm = (src_i == SP_HSL) ? {1'b0, s3_cq_q[16:1]} : s3_cq_q;

  logic [2:0]  s4_sector_q;
  logic [16:0] s4_cq_q;
  logic signed [26:0] s4_mq_q;
  logic [24:0] s4_xp_q;
  pix_t        s4_lin_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_sector_q <= s3_sector_q;
      s4_cq_q     <= s3_cq_q;
      s4_mq_q     <= $signed({3'b0, s3_c_q, 16'b0}) - $signed({10'b0, cqm});
      s4_xp_q     <= 25'(s3_cq_q) * 25'(s3_t_q);
      s4_lin_q    <= s3_lin_q;
    end
  end

  // Stage 5: X estimate by reciprocal of 255.
  logic [49:0] xprod;
  assign xprod = 50'(s4_xp_q) * 50'(RCP_255);

  logic [2:0]  s5_sector_q;
  logic [16:0] s5_cq_q, s5_xq0_q;
  logic signed [26:0] s5_mq_q;
  logic [24:0] s5_xp_q;
  pix_t        s5_lin_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_sector_q <= s4_sector_q;
      s5_cq_q     <= s4_cq_q;
      s5_mq_q     <= s4_mq_q;
      s5_xp_q     <= s4_xp_q;
      s5_xq0_q    <= xprod[48:32];
      s5_lin_q    <= s4_lin_q;
    end
  end

  // Stage 6: X correction and sector select.
  logic [25:0] xrem;
  logic [16:0] xq;
  logic signed [27:0] hi_s, mid_s;
  chan_t       hi, mid, lo;
  pix_t        rgb;

  always_comb begin
    xrem  = {1'b0, s5_xp_q} - 26'(s5_xq0_q) * 26'd255;
    xq    = s5_xq0_q + 17'(xrem >= 26'd255);
    hi_s  = $signed({11'b0, s5_cq_q}) + 28'(s5_mq_q);
    mid_s = $signed({11'b0, xq}) + 28'(s5_mq_q);
    hi    = sat8(32'(hi_s >>> 16));
    mid   = sat8(32'(mid_s >>> 16));
    lo    = sat8(32'(s5_mq_q >>> 16));
    if (src_i == SP_HSL || src_i == SP_HSV) begin
      case (s5_sector_q)
        3'd0:    rgb = '{a: hi,  b: mid, c: lo};
        3'd1:    rgb = '{a: mid, b: hi,  c: lo};
        3'd2:    rgb = '{a: lo,  b: hi,  c: mid};
        3'd3:    rgb = '{a: lo,  b: mid, c: hi};
        3'd4:    rgb = '{a: mid, b: lo,  c: hi};
        default: rgb = '{a: hi,  b: lo,  c: mid};
      endcase
    end else begin
      rgb = s5_lin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rgb_o <= rgb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:1], valid_i};
    end
  end

  assign valid_o = v_q[6];

endmodule

`default_nettype wire

[src/csc_from_rgb.sv]
`default_nettype none

module csc_from_rgb (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire csc_pkg::space_e tgt_i,
  input  wire csc_pkg::pix_t   rgb_i,
  output logic                 valid_o,
  output csc_pkg::pix_t        pix_o
);
  import csc_pkg::*;

  localparam int unsigned NDLY = 6;

  logic [9:1] v_q;

  chan_t       r, g, b, mx, mn, c, d, sat_den, lv;
  logic [10:0] n;
  logic [8:0]  s;
  logic        y709;
  logic [15:0] kr, kg, kb;
  logic [10:0] ya, yb2, yc;
  pix_t        simple;

  always_comb begin
    r  = rgb_i.a;
    g  = rgb_i.b;
    b  = rgb_i.c;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    c = mx - mn;
    if (mx == r) begin
      n = (g >= b) ? 11'(g) - 11'(b) : 11'(c) * 11'd6 + 11'(g) - 11'(b);
    end else if (mx == g) begin
      n = 11'(c) * 11'd2 + 11'(b) - 11'(r);
    end else begin
      n = 11'(c) * 11'd4 + 11'(r) - 11'(g);
    end
    s       = 9'(mx) + 9'(mn);
    d       = (s <= 9'd255) ? s[7:0] : 8'(9'd510 - s);
    sat_den = (tgt_i == SP_HSV) ? mx : d;
    lv      = (tgt_i == SP_HSV) ? mx : s[8:1];

    y709 = (tgt_i == SP_Y709);
    kr   = y709 ? K709_KR : K601_KR;
    kg   = y709 ? K709_KG : K601_KG;
    kb   = y709 ? K709_KB : K601_KB;

    ya  = (11'(r) + 11'(g) * 11'd2 + 11'(b)) >> 2;
    yb2 = (11'(r) - 11'(b) + 11'd255) >> 1;
    yc  = (11'(g) * 11'd2 - 11'(r) - 11'(b) + 11'd510) >> 2;

    case (tgt_i)
      SP_YCOCG: begin
        simple = '{a: ya[7:0], b: yb2[7:0], c: yc[7:0]};
      end
      SP_CMY: begin
        simple = '{a: ~r, b: ~g, c: ~b};
      end
      default: begin
        simple = rgb_i;
      end
    endcase
  end

  // Stage 1 registers.
  logic [18:0] hue_num_q;
  logic [10:0] hue_den_q;
  logic [15:0] sat_num_q;
  chan_t       sat_den_q, lv1_q, r1_q, b1_q;
  logic [23:0] pr_q, pg_q, pb_q;
  pix_t        simple1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_num_q <= 19'(n) * 19'd255;
      hue_den_q <= 11'(c) * 11'd6;
      sat_num_q <= 16'(c) * 16'd255;
      sat_den_q <= sat_den;
      lv1_q     <= lv;
      r1_q      <= r;
      b1_q      <= b;
      pr_q      <= 24'(kr) * 24'(r);
      pg_q      <= 24'(kg) * 24'(g);
      pb_q      <= 24'(kb) * 24'(b);
      simple1_q <= simple;
    end
  end

  chan_t hue, sat;

  csc_div #(.NW(19), .DW(11)) u_hue_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (hue_num_q),
    .den_i (hue_den_q),
    .quo_o (hue)
  );

  csc_div #(.NW(16), .DW(8)) u_sat_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (sat_num_q),
    .den_i (sat_den_q),
    .quo_o (sat)
  );

  // Stage 2: luma sum and color differences.
  logic [24:0] yq;
  assign yq = 25'(pr_q) + 25'(pg_q) + 25'(pb_q);

  chan_t y2_q, lv2_q;
  logic signed [25:0] db2_q, dr2_q;
  pix_t  simple2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y2_q      <= sat8($signed({23'b0, yq[24:16]}));
      db2_q     <= $signed({2'b0, b1_q, 16'b0}) - $signed({1'b0, yq});
      dr2_q     <= $signed({2'b0, r1_q, 16'b0}) - $signed({1'b0, yq});
      lv2_q     <= lv1_q;
      simple2_q <= simple1_q;
    end
  end

  // Stage 3: chroma scaling.
  logic [15:0] cb_f, cr_f;
  assign cb_f = y709 ? K709_CB_F : K601_CB_F;
  assign cr_f = y709 ? K709_CR_F : K601_CR_F;

  chan_t y3_q, lv3_q;
  logic signed [42:0] mb3_q, mr3_q;
  pix_t  simple3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y3_q      <= y2_q;
      mb3_q     <= db2_q * $signed({1'b0, cb_f});
      mr3_q     <= dr2_q * $signed({1'b0, cr_f});
      lv3_q     <= lv2_q;
      simple3_q <= simple2_q;
    end
  end

  // Stage 4: chroma offset and merge.
  logic signed [31:0] cbs, crs;
  pix_t oth;

  always_comb begin
    cbs = 32'(mb3_q >>> 16) + $signed({4'b0, HALF_OFF});
    crs = 32'(mr3_q >>> 16) + $signed({4'b0, HALF_OFF});
    if (tgt_i == SP_Y601 || tgt_i == SP_Y709) begin
      oth = '{a: y3_q, b: sat8(cbs >>> 16), c: sat8(crs >>> 16)};
    end else begin
      oth = simple3_q;
    end
  end

  pix_t  oth_q [NDLY];
  chan_t lv_q  [NDLY];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      oth_q[0] <= oth;
      lv_q[0]  <= lv3_q;
      for (int i = 1; i < NDLY; i++) begin
        oth_q[i] <= oth_q[i-1];
        lv_q[i]  <= lv_q[i-1];
      end
    end
  end

  always_comb begin
    if (tgt_i == SP_HSL || tgt_i == SP_HSV) begin
      pix_o = '{a: hue, b: sat, c: lv_q[NDLY-1]};
    end else begin
      pix_o = oth_q[NDLY-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[8:1], valid_i};
    end
  end

  assign valid_o = v_q[9];

endmodule

`default_nettype wire
